// ===== hdl/slmj_pkg.sv =====
package slmj_pkg;

	localparam int LIST_DEPTH = 32;

	localparam logic [1:0] KIND_LOAD_FIRST  = 2'd0;
	localparam logic [1:0] KIND_LOAD_SECOND = 2'd1;
	localparam logic [1:0] KIND_RUN         = 2'd2;

	localparam logic [1:0] ORIGIN_FIRST  = 2'd0;
	localparam logic [1:0] ORIGIN_SECOND = 2'd1;
	localparam logic [1:0] ORIGIN_BOTH   = 2'd2;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] doc_id;
		logic [31:0] score;
	} item_t;

	typedef struct packed {
		logic [31:0] out_id;
		logic [31:0] out_score;
		logic [1:0]  origin_list;
		logic        empty_run;
		logic        last;
	} result_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic wr_first;
		logic wr_second;
		logic start;
		logic emit_empty;
		logic step;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic full_first;
		logic full_second;
		logic run_empty;
		logic out_free;
		logic step_last;
	} status_t;

endpackage

// ===== hdl/sorted_list_merge_join_top.sv =====
// Merge-union of two scored document lists. Load words (kind first or second)
// append a (doc_id, score) entry to a list at one word per cycle; a load into
// a full list is dropped. A run word merges both lists in ascending id order
// and then empties them: equal ids give one word marked both, with the scores
// added and saturated, and a run over two empty lists gives a single word
// flagged empty_run. A run keeps the input stalled until the final result
// word of the run is produced: the PRIME state primes the registered read
// ports of the list memories, then one result follows per cycle, each step
// waiting on the single output register.
module sorted_list_merge_join_top #(
	parameter int LIST_DEPTH = slmj_pkg::LIST_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  slmj_pkg::item_t      item,
	output logic                 result_valid,
	input  logic                 result_stall,
	output slmj_pkg::result_t    result
);

	slmj_pkg::cmd_t    cmd;
	slmj_pkg::status_t sts;

	slmj_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.item_stall (item_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	slmj_dp #(
		.LIST_DEPTH (LIST_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.sts          (sts),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// A run word always closes the input side in the next cycle.
	a_run_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall && item.kind == slmj_pkg::KIND_RUN) |=> item_stall)
		else $error("input not stalled after run word");

	// The input side reopens only right after the final word of a run was produced.
	a_reopen_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(item_stall) |-> $past((cmd.step && sts.step_last) || cmd.emit_empty))
		else $error("input reopened before run finished");

	// An empty-run word is the only and final word of its run.
	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.empty_run) |->
		(result.last && result.origin_list == slmj_pkg::ORIGIN_FIRST && result.out_id == '0))
		else $error("malformed empty-run word");

endmodule

// ===== hdl/slmj_ctrl.sv =====
module slmj_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	input  slmj_pkg::item_t      item,
	output logic                 item_stall,
	input  slmj_pkg::status_t    sts,
	output slmj_pkg::cmd_t       cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_PRIME = 2'd1;
	localparam logic [1:0] ST_MERGE = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       accept;

	assign item_stall = (state_q != ST_IDLE);
	assign accept     = item_valid && !item_stall;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (item.kind)
						slmj_pkg::KIND_LOAD_FIRST:  cmd.wr_first  = !sts.full_first;
						slmj_pkg::KIND_LOAD_SECOND: cmd.wr_second = !sts.full_second;
						slmj_pkg::KIND_RUN: begin
							cmd.start = 1'b1;
							state_d   = ST_PRIME;
						end
						default: ;
					endcase
				end
			end
			// The first head entries are being read out of the list memories.
			ST_PRIME: state_d = ST_MERGE;
			ST_MERGE: begin
				if (sts.out_free) begin
					if (sts.run_empty) begin
						cmd.emit_empty = 1'b1;
						state_d        = ST_IDLE;
					end else begin
						cmd.step = 1'b1;
						if (sts.step_last) begin
							state_d = ST_IDLE;
						end
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== hdl/slmj_dp.sv =====
module slmj_dp #(
	parameter int LIST_DEPTH = slmj_pkg::LIST_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  slmj_pkg::item_t      item,
	input  slmj_pkg::cmd_t       cmd,
	output slmj_pkg::status_t    sts,
	output logic                 result_valid,
	input  logic                 result_stall,
	output slmj_pkg::result_t    result
);

	localparam int CW = $clog2(LIST_DEPTH + 1);
	localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

	logic [63:0] mem_first  [LIST_DEPTH];
	logic [63:0] mem_second [LIST_DEPTH];

	logic [CW-1:0] cnt_first_q, cnt_second_q;
	logic [CW-1:0] n_first_q, n_second_q;
	logic [CW-1:0] p_first_q, p_second_q;
	logic [CW-1:0] p_first_d, p_second_d;
	logic [63:0]   head_first_q, head_second_q;

	logic          has_first, has_second;
	logic          take_first, take_second, take_both;
	logic          adv_first, adv_second;
	logic [32:0]   sum;
	slmj_pkg::result_t step_res;

	logic              res_valid_q;
	slmj_pkg::result_t res_q;

	assign has_first  = (p_first_q < n_first_q);
	assign has_second = (p_second_q < n_second_q);

	assign take_first  = !has_second ||
	                     (has_first && (head_first_q[63:32] < head_second_q[63:32]));
	assign take_second = !take_first &&
	                     (!has_first || (head_first_q[63:32] > head_second_q[63:32]));
	assign take_both   = !take_first && !take_second;

	assign adv_first  = cmd.step && (take_first || take_both);
	assign adv_second = cmd.step && (take_second || take_both);

	assign p_first_d  = p_first_q + CW'(adv_first);
	assign p_second_d = p_second_q + CW'(adv_second);

	assign sum = {1'b0, head_first_q[31:0]} + {1'b0, head_second_q[31:0]};

	always_comb begin
		step_res           = '0;
		step_res.out_id    = take_second ? head_second_q[63:32] : head_first_q[63:32];
		if (take_first) begin
			step_res.out_score   = head_first_q[31:0];
			step_res.origin_list = slmj_pkg::ORIGIN_FIRST;
		end else if (take_second) begin
			step_res.out_score   = head_second_q[31:0];
			step_res.origin_list = slmj_pkg::ORIGIN_SECOND;
		end else begin
			step_res.out_score   = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
			step_res.origin_list = slmj_pkg::ORIGIN_BOTH;
		end
		step_res.last = sts.step_last;
	end

	assign sts.full_first  = (cnt_first_q == CW'(LIST_DEPTH));
	assign sts.full_second = (cnt_second_q == CW'(LIST_DEPTH));
	assign sts.run_empty   = (n_first_q == '0) && (n_second_q == '0);
	assign sts.out_free    = !res_valid_q || !result_stall;
	assign sts.step_last   = (p_first_q + CW'(take_first || take_both) >= n_first_q) &&
	                         (p_second_q + CW'(take_second || take_both) >= n_second_q);

	// List memories: one write port at the fill count, one registered read port
	// that is always pointed at the next head entry.
	always_ff @(posedge clk) begin
		if (cmd.wr_first) begin
			mem_first[cnt_first_q[AW-1:0]] <= {item.doc_id, item.score};
		end
		if (cmd.wr_second) begin
			mem_second[cnt_second_q[AW-1:0]] <= {item.doc_id, item.score};
		end
		head_first_q  <= mem_first[p_first_d[AW-1:0]];
		head_second_q <= mem_second[p_second_d[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_first_q  <= '0;
			cnt_second_q <= '0;
			n_first_q    <= '0;
			n_second_q   <= '0;
			p_first_q    <= '0;
			p_second_q   <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			if (cmd.start) begin
				n_first_q    <= cnt_first_q;
				n_second_q   <= cnt_second_q;
				cnt_first_q  <= '0;
				cnt_second_q <= '0;
				p_first_q    <= '0;
				p_second_q   <= '0;
			end else begin
				if (cmd.wr_first) begin
					cnt_first_q <= cnt_first_q + CW'(1);
				end
				if (cmd.wr_second) begin
					cnt_second_q <= cnt_second_q + CW'(1);
				end
				p_first_q  <= p_first_d;
				p_second_q <= p_second_d;
			end
			if (cmd.step || cmd.emit_empty) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_empty) begin
			res_q           <= '0;
			res_q.empty_run <= 1'b1;
			res_q.last      <= 1'b1;
		end else if (cmd.step) begin
			res_q <= step_res;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule
